/* rtl/hwc_pkg.sv */
// Package for the Hybla window controller: field widths, register indexes,
// opcodes, reset values and the divider status struct. No dependencies.
package hwc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    localparam int OPCODE_W = 2;
    localparam int RTT_W    = 16;
    localparam int WIN_W    = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ACK   = 2'd0,
        OP_LOSS  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RHO_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH = 3'd4;

    localparam logic [RTT_W-1:0] MIN_RTT_RST     = 16'd10;
    localparam logic [WIN_W-1:0] RHO_LIMIT_RST   = 32'd262144;
    localparam logic [WIN_W-1:0] WIN_LIMIT_RST   = 32'd4294901760;
    localparam logic [WIN_W-1:0] INIT_WIN_RST    = 32'd131072;
    localparam logic [WIN_W-1:0] INIT_THRESH_RST = 32'd4294901760;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

/* rtl/hwc_if.sv */
// Valid/ready channel interfaces for the Hybla window controller: event
// input and window result. Depends on hwc_pkg for field widths.
interface hwc_evt_if;
    logic                         valid;
    logic                         ready;
    logic [hwc_pkg::OPCODE_W-1:0] opcode;
    logic [hwc_pkg::RTT_W-1:0]    rtt_ms;

    modport source (output valid, output opcode, output rtt_ms, input ready);
    modport sink   (input valid, input opcode, input rtt_ms, output ready);
endinterface

interface hwc_res_if;
    logic                      valid;
    logic                      ready;
    logic [hwc_pkg::WIN_W-1:0] window;
    logic [hwc_pkg::WIN_W-1:0] threshold;

    modport source (output valid, output window, output threshold, input ready);
    modport sink   (input valid, input window, input threshold, output ready);
endinterface

/* rtl/hybla_window_control_unit.sv */
// Top level of the Hybla congestion window controller: configuration
// registers, window state, sequencer. Depends on hwc_pkg, hwc_if, hwc_divider.
//
// Each event takes one transaction on i_evt and yields one transaction on
// o_res. Loss, start and unused opcodes go straight from idle to the finish
// state. An ack runs two squarings on one shared 16x16 multiplier, then the
// rho division and, in congestion avoidance, the increment division on one
// shared restoring divider; slow start and a zero window skip the increment
// division. The finish state waits until a held result has left. i_evt is
// ready only while the sequencer is idle; a waiting result does not block
// the next event.
module hybla_window_control_unit #(
    parameter int FRAC_BITS = hwc_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hwc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hwc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    hwc_evt_if.sink                       i_evt,
    hwc_res_if.source                     o_res
);
    import hwc_pkg::*;

    localparam int NW = 2 * FRAC_BITS + 1;
    localparam int CW = $clog2(NW + 1);
    localparam int SW = ((NW > WIN_W) ? NW : WIN_W) + 1;

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_SQR_R   = 7'b0000010,
        S_SQR_B   = 7'b0000100,
        S_DIV_RHO = 7'b0001000,
        S_GROW    = 7'b0010000,
        S_DIV_INC = 7'b0100000,
        S_FIN     = 7'b1000000
    } t_state;

    t_state r_state;

    logic [RTT_W-1:0] r_min_rtt;
    logic [WIN_W-1:0] r_rho_limit, r_win_limit, r_init_win, r_init_thresh;
    logic [WIN_W-1:0] r_cwnd, r_ssth;
    logic [RTT_W-1:0] r_base;
    logic             r_base_valid;

    logic [RTT_W-1:0]   r_rtt;
    logic [31:0]        r_rsq;
    logic [FRAC_BITS:0] r_rho;

    logic             r_out_valid;
    logic [WIN_W-1:0] r_out_win, r_out_thr;

    logic [RTT_W-1:0] w_clamp;
    logic [WIN_W-1:0] w_half, w_floor;
    logic [RTT_W-1:0] w_mul_a;
    logic [31:0]      w_prod;
    logic             w_take;
    logic             w_res_load;

    logic          w_div_start;
    logic [31:0]   w_div_rem;
    logic [NW-1:0] w_div_num;
    logic [31:0]   w_div_den;
    logic [CW-1:0] w_div_steps;
    logic [NW-1:0] w_quo;
    t_div_sts      w_div_sts;

    logic [WIN_W-1:0] w_quo_ext;
    logic [FRAC_BITS:0] w_rho;
    logic [WIN_W:0]   w_ss_sum;
    logic [WIN_W-1:0] w_ss_win;
    logic [SW-1:0]    w_ca_sum;
    logic [WIN_W-1:0] w_ca_win;

    always_comb begin
        w_clamp = (i_evt.rtt_ms < r_min_rtt) ? r_min_rtt : i_evt.rtt_ms;
        if (w_clamp == '0) begin
            w_clamp = RTT_W'(1);
        end
    end

    assign w_half  = r_cwnd >> 1;
    assign w_floor = (w_half > r_init_win) ? w_half : r_init_win;

    assign w_mul_a = (r_state == S_SQR_R) ? r_rtt : r_base;
    assign w_prod  = 32'(w_mul_a) * 32'(w_mul_a);

    assign w_take = i_evt.valid && (r_state == S_IDLE);
    assign i_evt.ready = (r_state == S_IDLE);

    assign w_res_load = (r_state == S_FIN) && (!r_out_valid || o_res.ready);

    assign w_quo_ext = WIN_W'(w_quo[FRAC_BITS:0]);
    assign w_rho = (w_quo_ext > r_rho_limit) ? r_rho_limit[FRAC_BITS:0] : w_quo[FRAC_BITS:0];

    assign w_ss_sum = {1'b0, r_cwnd} + (WIN_W + 1)'(r_rho);
    assign w_ss_win = (w_ss_sum > {1'b0, r_win_limit}) ? r_win_limit : w_ss_sum[WIN_W-1:0];

    assign w_ca_sum = SW'(r_cwnd) + SW'(w_quo);
    assign w_ca_win = (w_ca_sum > SW'(r_win_limit)) ? r_win_limit : w_ca_sum[WIN_W-1:0];

    always_comb begin
        w_div_start = 1'b0;
        w_div_rem   = {1'b0, w_prod[31:1]};
        w_div_num   = {w_prod[0], {(NW-1){1'b0}}};
        w_div_den   = r_rsq;
        w_div_steps = CW'(FRAC_BITS + 1);
        if (r_state == S_SQR_B) begin
            w_div_start = 1'b1;
        end else if (r_state == S_GROW) begin
            w_div_start = (r_cwnd >= r_ssth) && (r_cwnd != '0);
            w_div_rem   = '0;
            w_div_num   = {r_rho, {FRAC_BITS{1'b0}}};
            w_div_den   = r_cwnd;
            w_div_steps = CW'(NW);
        end
    end

    hwc_divider #(
        .FRAC_BITS(FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_rem   (w_div_rem),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .i_steps (w_div_steps),
        .o_quo   (w_quo),
        .o_sts   (w_div_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_rtt     <= MIN_RTT_RST;
            r_rho_limit   <= RHO_LIMIT_RST;
            r_win_limit   <= WIN_LIMIT_RST;
            r_init_win    <= INIT_WIN_RST;
            r_init_thresh <= INIT_THRESH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_RTT:     r_min_rtt     <= i_cfg_data[RTT_W-1:0];
                CFG_RHO_LIMIT:   r_rho_limit   <= i_cfg_data[WIN_W-1:0];
                CFG_WIN_LIMIT:   r_win_limit   <= i_cfg_data[WIN_W-1:0];
                CFG_INIT_WIN:    r_init_win    <= i_cfg_data[WIN_W-1:0];
                CFG_INIT_THRESH: r_init_thresh <= i_cfg_data[WIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cwnd       <= INIT_WIN_RST;
            r_ssth       <= INIT_THRESH_RST;
            r_base       <= '0;
            r_base_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (w_res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        unique case (t_opcode'(i_evt.opcode))
                            OP_ACK: begin
                                if (!r_base_valid || (w_clamp < r_base)) begin
                                    r_base <= w_clamp;
                                end
                                r_base_valid <= 1'b1;
                                r_state      <= S_SQR_R;
                            end
                            OP_LOSS: begin
                                r_cwnd  <= w_floor;
                                r_ssth  <= w_floor;
                                r_base  <= w_clamp;
                                r_state <= S_FIN;
                            end
                            OP_START: begin
                                r_cwnd       <= r_init_win;
                                r_ssth       <= r_init_thresh;
                                r_base       <= '0;
                                r_base_valid <= 1'b0;
                                r_state      <= S_FIN;
                            end
                            OP_NONE: begin
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end
                S_SQR_R: begin
                    r_state <= S_SQR_B;
                end
                S_SQR_B: begin
                    r_state <= S_DIV_RHO;
                end
                S_DIV_RHO: begin
                    if (w_div_sts.done) begin
                        r_state <= S_GROW;
                    end
                end
                S_GROW: begin
                    if (r_cwnd < r_ssth) begin
                        r_cwnd  <= w_ss_win;
                        r_state <= S_FIN;
                    end else if (r_cwnd == '0) begin
                        r_cwnd  <= r_win_limit;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV_INC;
                    end
                end
                S_DIV_INC: begin
                    if (w_div_sts.done) begin
                        r_cwnd  <= w_ca_win;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (w_res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_rtt <= w_clamp;
        end
        if (r_state == S_SQR_R) begin
            r_rsq <= w_prod;
        end
        if ((r_state == S_DIV_RHO) && w_div_sts.done) begin
            r_rho <= w_rho;
        end
        if (w_res_load) begin
            r_out_win <= r_cwnd;
            r_out_thr <= r_ssth;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.window    = r_out_win;
    assign o_res.threshold = r_out_thr;

endmodule

/* rtl/hwc_divider.sv */
// Restoring divider, one quotient bit per cycle, 32-bit divisor.
// Depends on hwc_pkg for the status struct.
module hwc_divider #(
    parameter int FRAC_BITS = hwc_pkg::FRAC_BITS_DEF,
    localparam int NW = 2 * FRAC_BITS + 1,
    localparam int CW = $clog2(NW + 1)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [31:0]             i_rem,
    input  logic [NW-1:0]           i_num,
    input  logic [31:0]             i_den,
    input  logic [CW-1:0]           i_steps,
    output logic [NW-1:0]           o_quo,
    output hwc_pkg::t_div_sts       o_sts
);
    import hwc_pkg::*;

    logic [31:0]   r_rem, n_rem;
    logic [NW-1:0] r_num, n_num;
    logic [31:0]   r_den;
    logic [NW-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [32:0]   w_trial;
    logic [33:0]   w_diff;
    logic          w_ge;

    assign w_trial = {r_rem, r_num[NW-1]};
    assign w_diff  = {1'b0, w_trial} - {2'b00, r_den};
    assign w_ge    = ~w_diff[33];

    always_comb begin
        n_rem = w_ge ? w_diff[31:0] : w_trial[31:0];
        n_num = r_num << 1;
        n_quo = {r_quo[NW-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_rem;
            r_num <= i_num;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;
    assign o_sts = '{busy: r_busy, done: r_done};

endmodule

/* sim/hybla_window_control_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for hybla_window_control_unit: drives events through
// hwc_evt_if, checks window and threshold on hwc_res_if against a local model.
// Depends on hwc_pkg, hwc_if and the RTL of the unit.
module hybla_window_control_unit_tb;
    import hwc_pkg::*;

    localparam int FRAC_BITS     = FRAC_BITS_DEF;
    localparam int CLK_PERIOD_NS = 12;
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_EVENTS  = 140;

    typedef struct packed {
        t_opcode          op;
        logic [RTT_W-1:0] rtt;
    } t_hwc_event;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        logic [WIN_W-1:0] threshold;
    } t_window_pair;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    hwc_evt_if evt_ch ();
    hwc_res_if res_ch ();

    hybla_window_control_unit #(
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_evt     (evt_ch),
        .o_res     (res_ch)
    );

    // register shadow
    logic [RTT_W-1:0] cfg_min_rtt     = MIN_RTT_RST;
    logic [WIN_W-1:0] cfg_rho_limit   = RHO_LIMIT_RST;
    logic [WIN_W-1:0] cfg_win_limit   = WIN_LIMIT_RST;
    logic [WIN_W-1:0] cfg_init_win    = INIT_WIN_RST;
    logic [WIN_W-1:0] cfg_init_thresh = INIT_THRESH_RST;

    // window state
    logic [WIN_W-1:0] cwnd_q     = INIT_WIN_RST;
    logic [WIN_W-1:0] ssthresh_q = INIT_THRESH_RST;
    logic [RTT_W-1:0] base_rtt_q = '0;
    logic             base_seen  = 1'b0;

    t_hwc_event   event_backlog[$];
    t_window_pair window_expect_q[$];

    int  src_gap = 0;
    int  snk_gap = 0;
    int  sink_hold_left = 0;
    bit  sink_hold_arm = 1'b0;
    bit  quiet = 1'b0;
    int  faults = 0;
    int  results_checked = 0;
    int  settings_used = 1;
    int  op_count[4] = '{0, 0, 0, 0};

    always #(CLK_PERIOD_NS / 2.0) i_clk = ~i_clk;

    initial begin
        evt_ch.valid  = 1'b0;
        evt_ch.opcode = '0;
        evt_ch.rtt_ms = '0;
        res_ch.ready  = 1'b0;
    end

    task automatic note_fault(input string msg);
        faults++;
        if (faults <= 10) $display("[%0t] %s", $realtime, msg);
    endtask

    task automatic advance_window(input t_opcode op, input logic [RTT_W-1:0] rtt_in);
        logic [RTT_W-1:0] r;
        logic [63:0]      b;
        logic [63:0]      rho;
        logic [63:0]      grown;
        logic [WIN_W-1:0] half;
        logic [WIN_W-1:0] floor_win;
        t_window_pair     pair;
        r = rtt_in;
        if (r < cfg_min_rtt) r = cfg_min_rtt;
        if (r == '0) r = 16'd1;
        case (op)
            OP_ACK: begin
                if (!base_seen) begin
                    base_rtt_q = r;
                    base_seen  = 1'b1;
                end
                if (r < base_rtt_q) base_rtt_q = r;
                b   = 64'(base_rtt_q);
                rho = ((b * b) << FRAC_BITS) / (64'(r) * 64'(r));
                if (rho > 64'(cfg_rho_limit)) rho = 64'(cfg_rho_limit);
                if (cwnd_q < ssthresh_q) begin
                    grown = 64'(cwnd_q) + rho;
                end else if (cwnd_q == '0) begin
                    grown = 64'(cfg_win_limit);
                end else begin
                    grown = 64'(cwnd_q) + ((rho << FRAC_BITS) / 64'(cwnd_q));
                end
                if (grown > 64'(cfg_win_limit)) grown = 64'(cfg_win_limit);
                cwnd_q = grown[WIN_W-1:0];
            end
            OP_LOSS: begin
                half       = cwnd_q >> 1;
                floor_win  = (half > cfg_init_win) ? half : cfg_init_win;
                ssthresh_q = floor_win;
                cwnd_q     = floor_win;
                base_rtt_q = r;
            end
            OP_START: begin
                cwnd_q     = cfg_init_win;
                ssthresh_q = cfg_init_thresh;
                base_rtt_q = '0;
                base_seen  = 1'b0;
            end
            default: begin
            end
        endcase
        op_count[op]++;
        pair.window    = cwnd_q;
        pair.threshold = ssthresh_q;
        window_expect_q.push_back(pair);
    endtask

    always @(posedge i_clk) begin
        t_hwc_event nxt;
        if (!i_rst_n) begin
            evt_ch.valid <= 1'b0;
            src_gap      <= 0;
        end else begin
            if (evt_ch.valid && evt_ch.ready)
                advance_window(t_opcode'(evt_ch.opcode), evt_ch.rtt_ms);
            if (!(evt_ch.valid && !evt_ch.ready)) begin
                if (src_gap != 0) begin
                    src_gap      <= src_gap - 1;
                    evt_ch.valid <= 1'b0;
                end else if (!quiet && $urandom_range(0, 7) == 0) begin
                    src_gap      <= $urandom_range(0, 9);
                    evt_ch.valid <= 1'b0;
                end else if (event_backlog.size() != 0) begin
                    nxt = event_backlog.pop_front();
                    evt_ch.valid  <= 1'b1;
                    evt_ch.opcode <= nxt.op;
                    evt_ch.rtt_ms <= nxt.rtt;
                end else begin
                    evt_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) sink_hold_left <= 0;
        else if (sink_hold_arm) sink_hold_left <= LONG_HOLD;
        else if (sink_hold_left != 0) sink_hold_left <= sink_hold_left - 1;
    end

    always @(posedge i_clk) begin
        t_window_pair want;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            snk_gap      <= 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                results_checked++;
                if (window_expect_q.size() == 0) begin
                    note_fault($sformatf("unexpected result window=%h threshold=%h",
                                         res_ch.window, res_ch.threshold));
                end else begin
                    want = window_expect_q.pop_front();
                    if (res_ch.window !== want.window)
                        note_fault($sformatf("window mismatch: expected %h, got %h",
                                             want.window, res_ch.window));
                    if (res_ch.threshold !== want.threshold)
                        note_fault($sformatf("threshold mismatch: expected %h, got %h",
                                             want.threshold, res_ch.threshold));
                end
            end
            if (sink_hold_left != 0) begin
                res_ch.ready <= 1'b0;
            end else if (snk_gap != 0) begin
                snk_gap      <= snk_gap - 1;
                res_ch.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                snk_gap      <= $urandom_range(0, 9);
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    task automatic queue_event(input t_opcode op, input logic [RTT_W-1:0] rtt);
        t_hwc_event e;
        e.op  = op;
        e.rtt = rtt;
        event_backlog.push_back(e);
    endtask

    task automatic wait_drained();
        while (event_backlog.size() != 0 || evt_ch.valid || window_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [RTT_W-1:0] min_rtt,
                                 input logic [WIN_W-1:0] rho_lim,
                                 input logic [WIN_W-1:0] win_lim,
                                 input logic [WIN_W-1:0] init_win,
                                 input logic [WIN_W-1:0] init_thr);
        logic [CFG_DATA_W-1:0] vals[5];
        logic [CFG_IDX_W-1:0]  idxs[5];
        vals = '{{16'($urandom), min_rtt}, rho_lim, win_lim, init_win, init_thr};
        idxs = '{CFG_MIN_RTT, CFG_RHO_LIMIT, CFG_WIN_LIMIT, CFG_INIT_WIN, CFG_INIT_THRESH};
        for (int k = 0; k < 5; k++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idxs[k];
            i_cfg_data <= vals[k];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_min_rtt     = min_rtt;
        cfg_rho_limit   = rho_lim;
        cfg_win_limit   = win_lim;
        cfg_init_win    = init_win;
        cfg_init_thresh = init_thr;
        settings_used++;
        @(negedge i_clk);
    endtask

    initial begin
        int               centre;
        int               pick;
        logic [RTT_W-1:0] rtt;
        t_opcode          op;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: clamp, first ack, base tracking, loss, reload, unused opcode
        queue_event(OP_ACK, 16'd0);
        queue_event(OP_ACK, 16'hFFFF);
        queue_event(OP_ACK, 16'd5);
        queue_event(OP_ACK, 16'd10);
        queue_event(OP_ACK, 16'd20);
        queue_event(OP_LOSS, 16'd300);
        queue_event(OP_ACK, 16'd300);
        queue_event(OP_ACK, 16'd150);
        queue_event(OP_NONE, 16'd7);
        queue_event(OP_START, 16'd0);
        queue_event(OP_ACK, 16'd1);
        wait_drained();

        // zero clamp, window above the limit, loss past the limit
        load_settings(16'd0, 32'hFFFF_FFFF, 32'h0008_0000, 32'h0010_0000, 32'd0);
        queue_event(OP_START, 16'd0);
        queue_event(OP_ACK, 16'd0);
        queue_event(OP_LOSS, 16'hFFFF);
        queue_event(OP_ACK, 16'd3);
        wait_drained();

        // zero window in avoidance
        load_settings(16'd1, 32'd65536, 32'hFFFF_FFFF, 32'd0, 32'd0);
        queue_event(OP_START, 16'd0);
        queue_event(OP_ACK, 16'd3);
        queue_event(OP_ACK, 16'hFFFF);
        queue_event(OP_LOSS, 16'd1);
        queue_event(OP_NONE, 16'hFFFF);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p)
                0: load_settings(MIN_RTT_RST, RHO_LIMIT_RST, WIN_LIMIT_RST, INIT_WIN_RST,
                                 $urandom_range(32'h0004_0000, 32'h0040_0000));
                1: load_settings(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                 32'hFFFF_FFFF);
                2: load_settings(16'd1, 32'd0, 32'd0, 32'd0, 32'd0);
                default: load_settings(($urandom_range(0, 5) == 0) ? 16'd0
                                           : RTT_W'($urandom_range(1, 60)),
                                       $urandom_range(32'h0000_4000, 32'h0010_0000),
                                       ($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF
                                           : $urandom_range(32'h0004_0000, 32'h0400_0000),
                                       $urandom_range(32'h0000_8000, 32'h0008_0000),
                                       $urandom_range(32'h0001_0000, 32'h0100_0000));
            endcase
            if (p == RAND_PHASES - 1) quiet = 1'b1;
            centre = $urandom_range(5, 400);
            for (int n = 0; n < PHASE_EVENTS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    pick = $urandom_range(0, 99);
                    op   = (pick < 85) ? OP_ACK : (pick < 93) ? OP_LOSS
                         : (pick < 97) ? OP_START : OP_NONE;
                    rtt  = RTT_W'($urandom_range(centre / 2 + 1, centre * 2));
                end else begin
                    op  = t_opcode'($urandom_range(0, 3));
                    rtt = RTT_W'($urandom());
                end
                queue_event(op, rtt);
            end
            if (p == 3) begin
                repeat (3) @(negedge i_clk);
                sink_hold_arm = 1'b1;
                @(negedge i_clk);
                sink_hold_arm = 1'b0;
            end
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (window_expect_q.size() != 0)
            note_fault($sformatf("%0d results never arrived", window_expect_q.size()));

        $display("Covered %0d acks, %0d losses, %0d reloads, %0d unused opcodes under %0d settings;",
                 op_count[OP_ACK], op_count[OP_LOSS], op_count[OP_START], op_count[OP_NONE],
                 settings_used);
        $display("%0d results compared, %0d faults.", results_checked, faults);
        if (faults == 0) begin
            $display("hybla_window_control_unit regression: pass");
        end else begin
            $display("hybla_window_control_unit regression: fail");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD_NS * LIMIT_CYCLES);
        $display("hybla_window_control_unit regression: fail");
        $finish;
    end

endmodule
